// ===== hw/rtl/lfb_pkg.sv =====
// lfb_pkg: types, character codes and helpers shared by the line folder.
// No dependencies; imported by lfb_ctrl, lfb_dpath and the top level.
package lfb_pkg;

   localparam int CHAR_W            = 8;
   localparam int FOLD_W            = 5;
   localparam int MAX_WIDTH_DEFAULT = 31;

   localparam logic [CHAR_W-1:0] NL_CHAR    = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
   localparam logic [CHAR_W-1:0] TAB_CHAR   = 8'd9;

   localparam logic [FOLD_W-1:0] MIN_FOLD_WIDTH   = 5'd2;
   localparam logic [FOLD_W-1:0] FOLD_WIDTH_RESET = 5'd31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_SEND,
      ST_NL,
      ST_APPEND
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture the accepted input byte
      logic clear_idx;  // start a new emit run
      logic read;       // read the buffer at head + idx
      logic send_byte;  // push the read byte to the output register
      logic send_nl;    // push the newline beat and apply the cut or flush
      logic append;     // store the input byte in the segment
   } lfb_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_nl;      // held input byte is a newline
      logic do_cut;     // segment has reached the fold width
      logic emit_zero;  // no held bytes go out before the newline
      logic idx_last;   // current byte is the final held byte of the run
      logic out_free;   // output register can take a beat this cycle
   } lfb_sts_type;

   function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
      return (ch == SPACE_CHAR) || (ch == TAB_CHAR);
   endfunction

endpackage

// ===== hw/rtl/lfb_ctrl.sv =====
// lfb_ctrl: sequencer for the line folder; steps one input byte through
// decide, buffer read-out, newline and append. Depends on lfb_pkg.
module lfb_ctrl
   import lfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  lfb_sts_type sts,
   output lfb_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.is_nl || sts.do_cut) begin
               cmd.clear_idx = 1'b1;
               state_in      = sts.emit_zero ? ST_NL : ST_READ;
            end else begin
               // plain byte: buffered, no beat
               cmd.append = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (sts.out_free) begin
               cmd.send_byte = 1'b1;
               state_in      = sts.idx_last ? ST_NL : ST_READ;
            end
         end
         ST_NL: begin
            if (sts.out_free) begin
               cmd.send_nl = 1'b1;
               state_in    = sts.is_nl ? ST_IDLE : ST_APPEND;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/lfb_dpath.sv =====
// lfb_dpath: segment buffer (circular), fold bookkeeping, width register
// and output register of the line folder. Depends on lfb_pkg.
module lfb_dpath
   import lfb_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)(
   input  logic              clock,
   input  logic              reset,
   input  logic [CHAR_W-1:0] req_char,
   input  logic              csr_valid,
   input  logic [FOLD_W-1:0] csr_data,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [CHAR_W-1:0] rsp_char,
   output logic              rsp_last,
   input  lfb_cmd_type       cmd,
   output lfb_sts_type       sts
);

   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int DEPTH = 2 ** CW;

   logic [CHAR_W-1:0] buf_mem [DEPTH];

   logic [FOLD_W-1:0] fold_width_ff, fold_width_in;
   logic [CW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     blank_pos_ff, blank_pos_in;
   logic              blank_seen_ff, blank_seen_in;
   logic              drop_ff, drop_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CHAR_W-1:0] char_ff;
   logic [CHAR_W-1:0] last_char_ff;
   logic [CHAR_W-1:0] rd_data_ff;
   logic [CHAR_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;

   logic [FOLD_W-1:0] width_eff;
   logic              is_nl;
   logic              do_cut;
   logic              blank_cut;
   logic [CW-1:0]     emit_n;
   logic              out_free;
   logic              wr_en;
   logic [CW-1:0]     wr_addr;
   logic [CW-1:0]     rd_addr;

   always_comb begin
      if (fold_width_ff < MIN_FOLD_WIDTH) begin
         width_eff = MIN_FOLD_WIDTH;
      end else if (fold_width_ff > FOLD_W'(MAX_WIDTH)) begin
         width_eff = FOLD_W'(MAX_WIDTH);
      end else begin
         width_eff = fold_width_ff;
      end
   end

   assign is_nl    = (char_ff == NL_CHAR);
   assign do_cut   = (FOLD_W'(count_ff) >= width_eff);
   // cut before the last blank only when neither side of the cut is blank
   assign blank_cut = blank_seen_ff && (blank_pos_ff < count_ff)
                      && !is_blank(last_char_ff) && !is_blank(char_ff);
   assign emit_n   = (!is_nl && blank_cut) ? blank_pos_ff : count_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign sts.is_nl     = is_nl;
   assign sts.do_cut    = do_cut;
   assign sts.emit_zero = (emit_n == '0);
   assign sts.idx_last  = (idx_ff == CW'(emit_n - 1'b1));
   assign sts.out_free  = out_free;

   assign wr_en   = cmd.append && !(drop_ff && is_blank(char_ff));
   assign wr_addr = CW'(head_ff + count_ff);
   assign rd_addr = CW'(head_ff + idx_ff);

   always_comb begin
      fold_width_in = fold_width_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      blank_pos_in  = blank_pos_ff;
      blank_seen_in = blank_seen_ff;
      drop_in       = drop_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (csr_valid) begin
         fold_width_in = csr_data;
      end

      if (cmd.clear_idx) begin
         idx_in = '0;
      end else if (cmd.send_byte) begin
         idx_in = CW'(idx_ff + 1'b1);
      end

      if (cmd.send_byte || cmd.send_nl) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.send_nl) begin
         blank_pos_in  = '0;
         blank_seen_in = 1'b0;
         if (is_nl) begin
            count_in = '0;
            drop_in  = 1'b0;
         end else if (blank_cut) begin
            // the tail after the blank becomes the new segment
            head_in  = CW'(head_ff + blank_pos_ff + 1'b1);
            count_in = CW'(count_ff - blank_pos_ff - 1'b1);
            drop_in  = 1'b0;
         end else begin
            count_in = '0;
            drop_in  = 1'b1;
         end
      end

      if (cmd.append) begin
         drop_in = 1'b0;
         if (wr_en) begin
            count_in = CW'(count_ff + 1'b1);
            if (is_blank(char_ff)) begin
               blank_pos_in  = count_ff;
               blank_seen_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_width_ff <= FOLD_WIDTH_RESET;
         head_ff       <= '0;
         count_ff      <= '0;
         blank_pos_ff  <= '0;
         blank_seen_ff <= 1'b0;
         drop_ff       <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fold_width_ff <= fold_width_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         blank_pos_ff  <= blank_pos_in;
         blank_seen_ff <= blank_seen_in;
         drop_ff       <= drop_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         char_ff <= req_char;
      end
      if (wr_en) begin
         last_char_ff <= char_ff;
      end
      if (cmd.send_byte) begin
         rsp_data_ff <= rd_data_ff;
         rsp_last_ff <= 1'b0;
      end else if (cmd.send_nl) begin
         rsp_data_ff <= NL_CHAR;
         rsp_last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[wr_addr] <= char_ff;
      end
      if (cmd.read) begin
         rd_data_ff <= buf_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_char   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== hw/rtl/line_fold_at_last_blank_unit.sv =====
// line_fold_at_last_blank_unit: greedy word-wrap line folder, top level.
// Instantiates lfb_ctrl and lfb_dpath; depends on lfb_pkg.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tdata[7:0] in_char
//   rsp     | out | rsp_tvalid/rsp_tready | tdata[7:0] out_char, tlast last
//   csr     | in  | csr_valid/csr_ready   | csr_data[4:0] fold_width
//
// A byte that is only buffered passes through accept, then decide + append.
// A fold sending k held bytes steps through accept, decide, then for each held
// beat a buffer read and an output-register load by the sequencer, then the
// newline beat and the append; a newline input skips the append.
// Reset is synchronous; the buffer has no clearing pass and needs none.
// Output stalls hold the sequencer; req_tready is high only between bytes.
module line_fold_at_last_blank_unit
   import lfb_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [CHAR_W-1:0] req_tdata,   // [7:0] in_char
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CHAR_W-1:0] rsp_tdata,   // [7:0] out_char
   output logic              rsp_tlast,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [FOLD_W-1:0] csr_data
);

   lfb_cmd_type cmd;
   lfb_sts_type sts;

   assign csr_ready = 1'b1;

   lfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lfb_dpath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_char   (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_char   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

   // one byte in flight: no second accept right after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while previous byte still in work");

   // every run of beats closes with the newline
   a_last_is_nl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == NL_CHAR)
      else $error("final beat is not a newline");

   // buffer port is either read or written, never both
   a_buf_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.read && cmd.append))
      else $error("segment buffer read and append in the same cycle");

   // a beat is loaded only when the output register can take it
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.send_byte || cmd.send_nl) |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten while stalled");

endmodule
